// ===== hw/rtl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
// Holds the table geometry, status codes, state encoding and the
// command and status structs between controller and datapath. No dependencies.
package ffha_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 24;

	localparam int ADDR_W = 20;
	localparam int TOP_W  = 21;
	localparam int CAP_W  = 21;
	localparam int SUM_W  = TOP_W + 1;
	localparam int STAT_W = 3;
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W  = $clog2(MAX_BLOCKS);

	localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(1 << ADDR_W);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(65536);

	// Request kinds.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
	localparam logic [STAT_W-1:0] STAT_ZERO_NULL  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_HEAP_FULL  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 3'd3;
	localparam logic [STAT_W-1:0] STAT_UNKNOWN    = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ffha_state_t;

	// One entry of the block table.
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic              free;
	} ffha_entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ffha_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic hit;
		logic done;
		logic out_free;
	} ffha_sts_t;

endpackage

// ===== hw/rtl/ffha_ctrl.sv =====
// Sequencing controller of the first-fit heap allocator.
// Steps each item through accept, table walk and commit. Depends on ffha_pkg.
module ffha_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ffha_pkg::ffha_sts_t   sts,
	output ffha_pkg::ffha_cmd_t   cmd
);
	import ffha_pkg::*;

	ffha_state_t state_q;
	ffha_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.hit || sts.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FINISH: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ffha_dpath.sv =====
// Datapath of the first-fit heap allocator: block table memory, scan
// pipeline, heap top, block count, capacity register and result register.
// Depends on ffha_pkg; driven by ffha_ctrl.
module ffha_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffha_pkg::ffha_cmd_t            cmd,
	output ffha_pkg::ffha_sts_t            sts,
	input  logic                           req_type,
	input  logic [ffha_pkg::ADDR_W-1:0]    req_size,
	input  logic [ffha_pkg::ADDR_W-1:0]    free_addr,
	input  logic                           cfg_we,
	input  logic [ffha_pkg::CAP_W-1:0]     cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ffha_pkg::ADDR_W-1:0]    out_addr,
	output logic [ffha_pkg::STAT_W-1:0]    out_status
);
	import ffha_pkg::*;

	ffha_entry_t mem [MAX_BLOCKS];

	logic              type_q;
	logic [ADDR_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [TOP_W-1:0]  top_q;
	logic [CNT_W-1:0]  idx_q;

	logic              rdv_s1;
	logic [IDX_W-1:0]  ridx_s1;
	ffha_entry_t       rdata_s1;

	logic              found_q;
	logic [IDX_W-1:0]  found_idx_q;
	ffha_entry_t       found_q_entry_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [STAT_W-1:0] out_status_q;

	logic              trivial;
	logic              rd_en;
	logic              match;
	logic [TOP_W-1:0]  ent_payload;
	logic [SUM_W-1:0]  end_sum;
	logic              fits;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	ffha_entry_t       wr_entry;
	logic              cnt_inc;
	logic              cnt_dec;
	logic              top_load;
	logic [TOP_W-1:0]  top_d;
	logic [ADDR_W-1:0] res_addr;
	logic [STAT_W-1:0] res_status;

	// Zero-size allocate and null free settle without a table walk.
	assign trivial = (type_q == REQ_ALLOC) ? (size_q == '0) : (addr_q == '0);

	assign rd_en = cmd.scan && !trivial && (idx_q < count_q);

	assign ent_payload = {1'b0, rdata_s1.start} + TOP_W'(HEADER_BYTES);
	assign match = (type_q == REQ_ALLOC) ? (rdata_s1.free && (rdata_s1.size >= size_q))
	                                     : (ent_payload == {1'b0, addr_q});

	assign sts.hit      = cmd.scan && rdv_s1 && match;
	assign sts.done     = trivial || ((idx_q >= count_q) && !rdv_s1);
	assign sts.out_free = !out_valid_q || out_ready;

	assign end_sum = {1'b0, top_q} + SUM_W'(HEADER_BYTES) + SUM_W'(size_q);
	assign fits    = end_sum <= SUM_W'(cap_q);

	// Outcome of the item, applied when the controller commits.
	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = found_idx_q;
		wr_entry   = found_q_entry_q;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		top_load   = 1'b0;
		top_d      = top_q;
		res_addr   = '0;
		res_status = STAT_OK;
		if (trivial) begin
			res_status = STAT_ZERO_NULL;
		end else if (type_q == REQ_ALLOC) begin
			if (found_q) begin
				wr_en         = 1'b1;
				wr_entry.free = 1'b0;
				res_addr      = ADDR_W'({1'b0, found_q_entry_q.start} + TOP_W'(HEADER_BYTES));
			end else if (!fits) begin
				res_status = STAT_HEAP_FULL;
			end else if (count_q >= CNT_W'(MAX_BLOCKS)) begin
				res_status = STAT_TABLE_FULL;
			end else begin
				wr_en          = 1'b1;
				wr_idx         = count_q[IDX_W-1:0];
				wr_entry.start = top_q[ADDR_W-1:0];
				wr_entry.size  = size_q;
				wr_entry.free  = 1'b0;
				cnt_inc        = 1'b1;
				top_load       = 1'b1;
				top_d          = end_sum[TOP_W-1:0];
				res_addr       = ADDR_W'(top_q + TOP_W'(HEADER_BYTES));
			end
		end else begin
			if (!found_q) begin
				res_status = STAT_UNKNOWN;
			end else if ((CNT_W'(found_idx_q) + CNT_W'(1)) == count_q) begin
				// The last block is popped and the top falls back to its start.
				cnt_dec  = 1'b1;
				top_load = 1'b1;
				top_d    = {1'b0, found_q_entry_q.start};
			end else begin
				wr_en         = 1'b1;
				wr_entry.free = 1'b1;
			end
		end
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
		if (rd_en) begin
			rdata_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			size_q <= req_size;
			addr_q <= free_addr;
		end
		if (rd_en) begin
			ridx_s1 <= idx_q[IDX_W-1:0];
		end
		if (sts.hit) begin
			found_idx_q     <= ridx_s1;
			found_q_entry_q <= rdata_s1;
		end
		if (cmd.commit) begin
			out_addr_q   <= res_addr;
			out_status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			top_q       <= '0;
			idx_q       <= '0;
			rdv_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= (cfg_data > CAP_LIMIT) ? CAP_LIMIT : cfg_data;
			end
			rdv_s1 <= rd_en;
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (sts.hit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (cnt_inc) begin
					count_q <= count_q + CNT_W'(1);
				end else if (cnt_dec) begin
					count_q <= count_q - CNT_W'(1);
				end
				if (top_load) begin
					top_q <= top_d;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_addr   = out_addr_q;
	assign out_status = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCKS))
		else $error("block count exceeds table depth");

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= CAP_LIMIT)
		else $error("heap top beyond address space");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (top_q == '0))
		else $error("empty table with nonzero heap top");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

endmodule

// ===== hw/rtl/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator: stream ports, configuration
// port, and the controller and datapath. Depends on ffha_pkg, ffha_ctrl, ffha_dpath.
//
//   Channel   Signals                      Direction  Contents
//   s_axis    tvalid tready tdata tuser    in         allocate or free request
//   m_axis    tvalid tready tdata          out        granted address and status
//   cfg       valid ready data             in         heap capacity in bytes
//
// An item is accepted, its table entries are read one by one through the single read
// port of the table memory, which is registered, and its result is committed; a walk
// that finds no match ends once it sees that it ran off the end of the table. The walk
// stops at the first matching entry; zero-size and null requests skip it, as does an
// empty table.
// Reset clears the block count and heap top and sets capacity to 65536; the
// table memory itself is not cleared, since only entries below the count are read.
// A stalled result stays in the output register; the next item is accepted and
// worked on meanwhile, and only its commit waits for the register to drain.
module first_fit_heap_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [19:0] req_size, [39:20] free_addr
	input  logic [39:0]                 s_axis_tdata,
	// [0] req_type
	input  logic                        s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [19:0] result_addr, [22:20] status, [23] zero
	output logic [23:0]                 m_axis_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ffha_pkg::CAP_W-1:0]  cfg_data
);
	import ffha_pkg::*;

	ffha_cmd_t         cmd;
	ffha_sts_t         sts;
	logic [ADDR_W-1:0] res_addr;
	logic [STAT_W-1:0] res_status;

	// Capacity is always writable; the user must write only while idle; not enforced.
	assign cfg_ready = 1'b1;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffha_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (s_axis_tuser),
		.req_size   (s_axis_tdata[ADDR_W-1:0]),
		.free_addr  (s_axis_tdata[2*ADDR_W-1:ADDR_W]),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_addr   (res_addr),
		.out_status (res_status)
	);

	// Result item packed with the address in the low bits, padded to whole bytes.
	assign m_axis_tdata = {1'b0, res_status, res_addr};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for first_fit_heap_allocator_unit: predicts each grant and status
// from its own model of the block table and heap top, under random stalls on both streams.
// Depends on ffha_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;
	import ffha_pkg::*;

	localparam int SETTLE_CYCLES = MAX_BLOCKS + 8;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [STAT_W-1:0] status;
	} grant_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [39:0]         s_axis_tdata;
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [23:0]         m_axis_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_W-1:0]    cfg_data;

	// Mirror of the allocator state, updated as each item is accepted.
	logic [ADDR_W-1:0]   blk_start [MAX_BLOCKS];
	logic [ADDR_W-1:0]   blk_size [MAX_BLOCKS];
	bit                  blk_free [MAX_BLOCKS];
	int                  blk_count;
	logic [TOP_W-1:0]    heap_top_m;
	logic [CAP_W-1:0]    heap_cap_m;

	grant_t              grants_due[$];
	int                  fail_count;
	int                  items_sent;
	int                  results_checked;
	int                  cap_writes;
	bit                  idle_on;
	int                  sink_hold;
	int                  sink_stall;

	first_fit_heap_allocator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] payload_of(int idx);
		return ADDR_W'(blk_start[idx] + HEADER_BYTES);
	endfunction

	// Works out the result of one request and advances the mirrored state.
	function automatic grant_t predict_grant(logic kind, logic [ADDR_W-1:0] size,
			logic [ADDR_W-1:0] addr);
		grant_t g;
		int idx;
		g.addr = '0;
		g.status = STAT_OK;
		if (kind == REQ_ALLOC) begin
			if (size == 0) begin
				g.status = STAT_ZERO_NULL;
				return g;
			end
			// First fit: the whole free block is reused, never split.
			for (idx = 0; idx < blk_count; idx++) begin
				if (blk_free[idx] && blk_size[idx] >= size) begin
					blk_free[idx] = 1'b0;
					g.addr = payload_of(idx);
					return g;
				end
			end
			// The heap check comes before the table check.
			if (heap_top_m + HEADER_BYTES + size > heap_cap_m) begin
				g.status = STAT_HEAP_FULL;
			end else if (blk_count >= MAX_BLOCKS) begin
				g.status = STAT_TABLE_FULL;
			end else begin
				blk_start[blk_count] = ADDR_W'(heap_top_m);
				blk_size[blk_count] = size;
				blk_free[blk_count] = 1'b0;
				blk_count++;
				g.addr = ADDR_W'(heap_top_m + HEADER_BYTES);
				heap_top_m = TOP_W'(heap_top_m + HEADER_BYTES + size);
			end
		end else begin
			if (addr == 0) begin
				g.status = STAT_ZERO_NULL;
				return g;
			end
			for (idx = 0; idx < blk_count; idx++) begin
				if (payload_of(idx) == addr) begin
					// Only the last block is popped; free blocks below it stay.
					if (idx + 1 == blk_count) begin
						heap_top_m = TOP_W'(blk_start[idx]);
						blk_count--;
					end else begin
						blk_free[idx] = 1'b1;
					end
					return g;
				end
			end
			g.status = STAT_UNKNOWN;
		end
		return g;
	endfunction

	// Sends one request; valid stays high for a following item unless a gap is taken.
	task automatic send_item(logic kind, logic [ADDR_W-1:0] size, logic [ADDR_W-1:0] addr);
		if (idle_on && $urandom_range(0, 99) < 15) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {addr, size};
		do @(posedge clk); while (!s_axis_tready);
		grants_due.push_back(predict_grant(kind, size, addr));
		items_sent++;
	endtask

	// Stops offering items and waits until the block has delivered every result.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		heap_cap_m = (value > CAP_LIMIT) ? CAP_LIMIT : value;
		cap_writes++;
	endtask

	task automatic test_directed();
		send_item(REQ_ALLOC, 20'd0, 20'hFFFFF);
		send_item(REQ_FREE, 20'hFFFFF, 20'd0);
		send_item(REQ_FREE, 20'd0, 20'hFFFFF);
		send_item(REQ_ALLOC, 20'd100, 20'd0);
		send_item(REQ_ALLOC, 20'd200, 20'd0);
		send_item(REQ_ALLOC, 20'd50, 20'd0);
		send_item(REQ_ALLOC, 20'hFFFFF, 20'd0);
		// Free a middle block twice, then miss it by one byte.
		send_item(REQ_FREE, 20'd0, payload_of(1));
		send_item(REQ_FREE, 20'd0, payload_of(1));
		send_item(REQ_FREE, 20'd0, payload_of(1) + 20'd1);
		// Freeing the last block pops only that block.
		send_item(REQ_FREE, 20'd0, payload_of(2));
		send_item(REQ_ALLOC, 20'd300, 20'd0);
		send_item(REQ_ALLOC, 20'd150, 20'd0);
		send_item(REQ_FREE, 20'd0, payload_of(0));
		send_item(REQ_ALLOC, 20'd100, 20'd0);
		// Exact fit up to the capacity, then one byte too many.
		send_item(REQ_ALLOC, ADDR_W'(heap_cap_m - heap_top_m - HEADER_BYTES), 20'd0);
		send_item(REQ_ALLOC, 20'd1, 20'd0);
		send_item(REQ_FREE, 20'hFFFFF, payload_of(blk_count - 1));
		send_item(REQ_FREE, 20'd0, payload_of(blk_count - 1));
		send_item(REQ_FREE, 20'd0, payload_of(0));
		send_item(REQ_FREE, 20'd0, payload_of(0));
	endtask

	task automatic release_all();
		while (blk_count > 0) send_item(REQ_FREE, 20'($urandom), payload_of(blk_count - 1));
	endtask

	task automatic test_table_full();
		int guard;
		write_capacity(21'h1FFFFF);
		guard = 0;
		while (blk_count < MAX_BLOCKS && guard < 4 * MAX_BLOCKS) begin
			send_item(REQ_ALLOC, 20'($urandom_range(1, 64)), 20'($urandom));
			guard++;
		end
		send_item(REQ_ALLOC, 20'd100000, 20'd0);
		// Heap full wins over table full.
		send_item(REQ_ALLOC, 20'hFFFFF, 20'd0);
		send_item(REQ_FREE, 20'd0, payload_of(10));
		send_item(REQ_FREE, 20'd0, payload_of(20));
		send_item(REQ_ALLOC, 20'd1, 20'd0);
		release_all();
	endtask

	task automatic test_capacity();
		write_capacity(CAP_RESET);
		send_item(REQ_ALLOC, 20'd400, 20'd0);
		send_item(REQ_ALLOC, 20'd800, 20'd0);
		send_item(REQ_ALLOC, 20'd100, 20'd0);
		send_item(REQ_FREE, 20'd0, payload_of(1));
		// Capacity below the top: reuse still works, appends fail.
		write_capacity('0);
		send_item(REQ_ALLOC, 20'd1, 20'd0);
		send_item(REQ_ALLOC, 20'd1, 20'd0);
		write_capacity(CAP_LIMIT + 21'd1);
		send_item(REQ_ALLOC, ADDR_W'(heap_cap_m - heap_top_m - HEADER_BYTES), 20'd0);
		send_item(REQ_ALLOC, 20'd1, 20'd0);
		release_all();
	endtask

	task automatic test_backpressure();
		int k;
		drain();
		sink_hold = 400;
		for (k = 0; k < 12; k++) send_item(k % 3 == 2 ? REQ_FREE : REQ_ALLOC,
			20'($urandom_range(1, 300)), blk_count > 0 ? payload_of(blk_count - 1) : 20'd7);
		release_all();
	endtask

	// Mostly well-formed traffic: allocations and frees of live blocks, with some noise.
	task automatic test_random(int n_ops, int max_size);
		int k;
		int roll;
		int idx;
		int live[$];
		logic [ADDR_W-1:0] size;
		for (k = 0; k < n_ops; k++) begin
			roll = $urandom_range(0, 99);
			live.delete();
			for (idx = 0; idx < blk_count; idx++) if (!blk_free[idx]) live.push_back(idx);
			if (roll < 55) begin
				case ($urandom_range(0, 19))
					0: size = '0;
					1: size = 20'($urandom);
					default: size = 20'($urandom_range(1, max_size));
				endcase
				send_item(REQ_ALLOC, size, 20'($urandom));
			end else if (roll < 88 && live.size() > 0) begin
				send_item(REQ_FREE, 20'($urandom),
					payload_of(live[$urandom_range(0, live.size() - 1)]));
			end else if (roll < 93 && blk_count > 0) begin
				send_item(REQ_FREE, 20'($urandom),
					payload_of($urandom_range(0, blk_count - 1)));
			end else if (roll < 98) begin
				send_item(REQ_FREE, 20'($urandom), 20'($urandom));
			end else begin
				send_item(REQ_FREE, 20'($urandom), 20'd0);
			end
		end
	endtask

	// Result side: random stall bursts, plus a long hold-off when one is requested.
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				m_axis_tready <= 1'b0;
				sink_hold--;
			end else if (sink_stall > 0) begin
				m_axis_tready <= 1'b0;
				sink_stall--;
			end else begin
				m_axis_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 99) < 6) sink_stall = $urandom_range(1, 19);
			end
		end
	end

	always @(posedge clk) begin : check_results
		grant_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (grants_due.size() == 0) begin
				$error("result with no request outstanding: tdata %h", m_axis_tdata);
				fail_count++;
			end else begin
				due = grants_due.pop_front();
				results_checked++;
				if (m_axis_tdata[19:0] !== due.addr) begin
					$error("result_addr expected %0d actual %0d", due.addr, m_axis_tdata[19:0]);
					fail_count++;
				end
				if (m_axis_tdata[22:20] !== due.status) begin
					$error("status expected %0d actual %0d", due.status, m_axis_tdata[22:20]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= REQ_ALLOC;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		blk_count = 0;
		heap_top_m = '0;
		heap_cap_m = CAP_RESET;
		fail_count = 0;
		items_sent = 0;
		results_checked = 0;
		cap_writes = 0;
		idle_on = 1'b1;
		sink_hold = 0;
		sink_stall = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_capacity();
		test_backpressure();
		write_capacity(CAP_RESET);
		test_random(90, 512);
		write_capacity(21'd3000);
		test_random(60, 256);
		write_capacity(CAP_LIMIT);
		test_random(80, 4096);
		idle_on = 1'b0;
		test_random(40, 4096);

		drain();
		if (grants_due.size() != 0) begin
			$error("%0d results never arrived", grants_due.size());
			fail_count++;
		end
		$display("Sent %0d requests and checked %0d results over %0d capacity writes,",
			items_sent, results_checked, cap_writes);
		$display("covering reuse, appends, pops, full heap and table, and bad frees.");
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== first_fit_heap_allocator_unit.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/ffha_dpath.sv
hw/rtl/first_fit_heap_allocator_unit.sv
tb/tb.sv
